@@ rtl/gia_pkg.sv @@
// shared types and constants for the generational index allocator
// no dependencies

package gia_pkg;

  // slot table size and derived widths
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned GEN_W    = 16;

  // fixed field widths of the channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned HIDX_W    = 8;
  localparam int unsigned HGEN_W    = 16;
  localparam int unsigned STATUS_W  = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FAIL       = 2'd1,
    ST_RANGE      = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic pop;
    logic exec;
  } gia_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_needed;
    logic out_free;
  } gia_stat_t;

endpackage

@@ rtl/gia_req_if.sv @@
// request channel: valid/ready handshake with opcode and handle
// depends on gia_pkg

interface gia_req_if
  import gia_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [HIDX_W-1:0] handle_index;
  logic [HGEN_W-1:0] handle_gen;

  modport source (output valid, output opcode, output handle_index, output handle_gen,
                  input ready);
  modport sink   (input valid, input opcode, input handle_index, input handle_gen,
                  output ready);
endinterface

@@ rtl/gia_rsp_if.sv @@
// response channel: valid/ready handshake with status and new handle
// depends on gia_pkg

interface gia_rsp_if
  import gia_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HIDX_W-1:0]   out_index;
  logic [HGEN_W-1:0]   out_gen;

  modport source (output valid, output status, output out_index, output out_gen,
                  input ready);
  modport sink   (input valid, input status, input out_index, input out_gen,
                  output ready);
endinterface

@@ rtl/gia_ctrl.sv @@
// sequencing state machine of the allocator
// depends on gia_pkg; drives the commands of gia_datapath

module gia_ctrl
  import gia_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  gia_stat_t stat_i,
  output gia_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.pop_needed ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/gia_datapath.sv @@
// slot memories, free stack, counters and response register
// depends on gia_pkg; controlled by gia_ctrl

module gia_datapath
  import gia_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [OP_W-1:0]     req_opcode_i,
  input  logic [HIDX_W-1:0]   req_index_i,
  input  logic [HGEN_W-1:0]   req_gen_i,
  input  gia_cmd_t            cmd_i,
  output gia_stat_t           stat_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [HIDX_W-1:0]   rsp_index_o,
  output logic [HGEN_W-1:0]   rsp_gen_o
);

  // memories
  logic [GEN_W-1:0] gen_mem   [CAPACITY];
  logic             live_mem  [CAPACITY];
  logic [IDX_W-1:0] stack_mem [CAPACITY];

  // request beat registers
  logic [OP_W-1:0]   op_q;
  logic [HIDX_W-1:0] idx_q;
  logic [HGEN_W-1:0] hgen_q;

  // counters
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] used_count_q, used_count_d;

  // read data
  logic [GEN_W-1:0] gen_rd_q;
  logic             live_rd_q;
  logic [IDX_W-1:0] stack_rd_q;

  // response register
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [HIDX_W-1:0]   rsp_index_q, rsp_index_d;
  logic [HGEN_W-1:0]   rsp_gen_q, rsp_gen_d;

  // memory port controls
  logic             slot_re;
  logic [IDX_W-1:0] slot_ra;
  logic             gen_we, live_we, live_wd, stack_we;
  logic [IDX_W-1:0] gen_wa, live_wa, stack_wa;
  logic [GEN_W-1:0] gen_wd;
  logic [IDX_W-1:0] stack_wd;
  logic [IDX_W-1:0] top_addr;
  logic [IDX_W-1:0] req_slot;

  logic stack_empty, used_full, stack_full, idx_in_range;

  assign stack_empty  = (free_count_q == '0);
  assign used_full    = (used_count_q == CNT_W'(CAPACITY));
  assign stack_full   = (free_count_q == CNT_W'(CAPACITY));
  assign idx_in_range = ({1'b0, idx_q} < used_count_q);
  assign top_addr     = IDX_W'(free_count_q - CNT_W'(1));
  assign req_slot     = IDX_W'(req_index_i);

  // status toward the controller
  assign stat_o.pop_needed = (req_opcode_i == OP_ALLOC) && !stack_empty;
  assign stat_o.out_free   = !rsp_valid_q || rsp_ready_i;

  // slot read address: fresh slot or handle on accept, popped slot after a pop
  always_comb begin
    slot_re = cmd_i.accept || cmd_i.pop;
    if (cmd_i.pop) begin
      slot_ra = stack_rd_q;
    end else if (req_opcode_i == OP_ALLOC) begin
      slot_ra = used_count_q[IDX_W-1:0];
    end else begin
      slot_ra = req_slot;
    end
  end

  // capture the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= req_opcode_i;
      idx_q  <= req_index_i;
      hgen_q <= req_gen_i;
    end
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (slot_re) begin
      gen_rd_q <= gen_mem[slot_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (slot_re) begin
      live_rd_q <= live_mem[slot_ra];
    end
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (cmd_i.accept) begin
      stack_rd_q <= stack_mem[top_addr];
    end
  end

  // execute step: decide result and updates
  always_comb begin
    free_count_d = free_count_q;
    used_count_d = used_count_q;
    gen_we       = 1'b0;
    gen_wa       = stack_rd_q;
    gen_wd       = '0;
    live_we      = 1'b0;
    live_wa      = idx_q[IDX_W-1:0];
    live_wd      = 1'b0;
    stack_we     = 1'b0;
    stack_wa     = free_count_q[IDX_W-1:0];
    stack_wd     = idx_q[IDX_W-1:0];
    rsp_status_d = ST_FAIL;
    rsp_index_d  = '0;
    rsp_gen_d    = '0;
    if (cmd_i.exec) begin
      case (op_q)
        OP_ALLOC: begin
          if (!stack_empty) begin
            // reuse the most recently freed slot with a bumped generation
            free_count_d = free_count_q - CNT_W'(1);
            gen_we       = 1'b1;
            gen_wa       = stack_rd_q;
            gen_wd       = gen_rd_q + GEN_W'(1);
            live_we      = 1'b1;
            live_wa      = stack_rd_q;
            live_wd      = 1'b1;
            rsp_status_d = ST_OK;
            rsp_index_d  = HIDX_W'(stack_rd_q);
            rsp_gen_d    = HGEN_W'(gen_rd_q + GEN_W'(1));
          end else if (!used_full) begin
            // first use of a fresh slot
            used_count_d = used_count_q + CNT_W'(1);
            gen_we       = 1'b1;
            gen_wa       = used_count_q[IDX_W-1:0];
            gen_wd       = '0;
            live_we      = 1'b1;
            live_wa      = used_count_q[IDX_W-1:0];
            live_wd      = 1'b1;
            rsp_status_d = ST_OK;
            rsp_index_d  = HIDX_W'(used_count_q[IDX_W-1:0]);
          end else begin
            rsp_status_d = ST_FAIL;
          end
        end
        OP_FREE: begin
          if (!idx_in_range) begin
            rsp_status_d = ST_RANGE;
          end else if (stack_full) begin
            rsp_status_d = ST_STACK_FULL;
          end else begin
            free_count_d = free_count_q + CNT_W'(1);
            live_we      = 1'b1;
            live_wd      = 1'b0;
            stack_we     = 1'b1;
            rsp_status_d = ST_OK;
          end
        end
        OP_CHECK: begin
          if (idx_in_range && live_rd_q && (hgen_q == HGEN_W'(gen_rd_q))) begin
            rsp_status_d = ST_OK;
          end else begin
            rsp_status_d = ST_FAIL;
          end
        end
        default: rsp_status_d = ST_FAIL;
      endcase
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      used_count_q <= '0;
    end else begin
      free_count_q <= free_count_d;
      used_count_q <= used_count_d;
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_status_q <= rsp_status_d;
      rsp_index_q  <= rsp_index_d;
      rsp_gen_q    <= rsp_gen_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_index_o  = rsp_index_q;
  assign rsp_gen_o    = rsp_gen_q;

  // checks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= CNT_W'(CAPACITY))
    else $error("free count above capacity");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= CNT_W'(CAPACITY))
    else $error("used count above capacity");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_status_q != ST_OK) |-> (rsp_index_q == '0) && (rsp_gen_q == '0))
    else $error("failed response carries a handle");

  a_exec_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> rsp_valid_q)
    else $error("executed request left no response");

endmodule

@@ rtl/generational_index_allocator_unit.sv @@
// Generational index allocator: hands out, frees and checks handles made
// of a slot index and a 16-bit generation.
// Channels: req_i (sink) carries opcode, handle_index, handle_gen; rsp_o
// (source) carries status, out_index, out_gen. A beat moves when valid and
// ready are both high; every request beat yields exactly one response beat.
// One request is in flight at a time. The request beat is registered with
// its slot reads, then the update step writes the response register; an
// allocate that reuses a freed slot reads the free stack first, then the
// slot generation, then updates. The next request beat can come once the
// controller is back in idle. The single read port of each slot memory sets this.
// The response sits in an output register: a new request is taken while
// an earlier response is still waiting; if the receiver stalls, the next
// request holds in its update step until the register frees up.
// Reset clears the free and used counters and the handshake state; the slot
// memories and the free stack need no clearing, since only entries already
// written are ever used.
// depends on gia_pkg, gia_req_if, gia_rsp_if, gia_ctrl, gia_datapath

module generational_index_allocator_unit
  import gia_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gia_req_if.sink    req_i,
  gia_rsp_if.source  rsp_o
);

  gia_cmd_t  cmd;
  gia_stat_t stat;

  // sequencer
  gia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and result logic
  gia_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_opcode_i (req_i.opcode),
    .req_index_i  (req_i.handle_index),
    .req_gen_i    (req_i.handle_gen),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_index_o  (rsp_o.out_index),
    .rsp_gen_o    (rsp_o.out_gen)
  );

endmodule
